### hdl/bltt_pkg.sv
package bltt_pkg;

    // Result queue between the classifier and the output sequencer
    localparam int QUEUE_DEPTH = 4;

    // Token kinds
    localparam logic [5:0] TK_STRING     = 6'd4;
    localparam logic [5:0] TK_SET_INT    = 6'd5;
    localparam logic [5:0] TK_SET_STRING = 6'd8;
    localparam logic [5:0] TK_ASSIGN     = 6'd20;
    localparam logic [5:0] TK_SET_LABEL  = 6'd21;
    localparam logic [5:0] TK_GOTO       = 6'd22;
    localparam logic [5:0] TK_IF         = 6'd23;
    localparam logic [5:0] TK_ELSE       = 6'd24;
    localparam logic [5:0] TK_WHILE      = 6'd25;
    localparam logic [5:0] TK_BEGIN      = 6'd26;
    localparam logic [5:0] TK_END        = 6'd27;
    localparam logic [5:0] TK_GET_VAR    = 6'd35;
    localparam logic [5:0] TK_EXIT       = 6'd36;
    // Plain operator tokens map to opcodes by a fixed offset
    localparam logic [5:0] TK_OP_OFFSET  = 6'd7;

    // Opcodes
    localparam logic [4:0] OP_PUSH      = 5'd0;
    localparam logic [4:0] OP_SET_TYPE  = 5'd1;
    localparam logic [4:0] OP_SET_LABEL = 5'd14;
    localparam logic [4:0] OP_GOTO      = 5'd15;
    localparam logic [4:0] OP_IF        = 5'd16;
    localparam logic [4:0] OP_ELSE      = 5'd17;
    localparam logic [4:0] OP_WHILE     = 5'd18;
    localparam logic [4:0] OP_BEGIN     = 5'd19;
    localparam logic [4:0] OP_END       = 5'd20;
    localparam logic [4:0] OP_EXIT      = 5'd29;

    // Operand kinds
    localparam logic [3:0] OK_NAME  = 4'd1;
    localparam logic [3:0] OK_TYPE  = 4'd6;
    localparam logic [3:0] OK_BLOCK = 4'd7;
    localparam logic [3:0] OK_USER  = 4'd8;

    // Block kinds on the nesting stack; they equal the plain label kinds
    localparam logic [1:0] BK_IF    = 2'd1;
    localparam logic [1:0] BK_ELSE  = 2'd2;
    localparam logic [1:0] BK_WHILE = 2'd3;

    // Label kinds
    localparam logic [3:0] LK_IF        = 4'd1;
    localparam logic [3:0] LK_ELSE      = 4'd2;
    localparam logic [3:0] LK_WHILE     = 4'd3;
    localparam logic [3:0] LK_BEGIN_OFS = 4'd3;
    localparam logic [3:0] LK_END_OFS   = 4'd6;

    // Error codes
    localparam logic [2:0] ERR_OK         = 3'd0;
    localparam logic [2:0] ERR_ELSE       = 3'd1;
    localparam logic [2:0] ERR_BEGIN      = 3'd2;
    localparam logic [2:0] ERR_END        = 3'd3;
    localparam logic [2:0] ERR_OPEN_IF    = 3'd4;
    localparam logic [2:0] ERR_OPEN_ELSE  = 3'd5;
    localparam logic [2:0] ERR_OPEN_WHILE = 3'd6;
    localparam logic [2:0] ERR_OVERFLOW   = 3'd7;

    // Narrow code fields of one result
    typedef struct packed {
        logic [4:0] opcode;
        logic [3:0] operand_kind;
        logic [1:0] type_code;
        logic [3:0] label_kind;
        logic [2:0] error_code;
    } t_code;

endpackage

### hdl/bltt_if.sv
interface bltt_token_if #(
    parameter int HANDLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [5:0]             token_kind;
    logic [HANDLE_BITS-1:0] text_handle;
    logic                   end_of_program;

    modport source (output valid, token_kind, text_handle, end_of_program, input ready);
    modport sink   (input valid, token_kind, text_handle, end_of_program, output ready);
endinterface

interface bltt_instr_if #(
    parameter int HANDLE_BITS = 16,
    parameter int LABEL_BITS  = 16
);
    logic                   valid;
    logic                   ready;
    logic [4:0]             opcode;
    logic [3:0]             operand_kind;
    logic [HANDLE_BITS-1:0] operand_handle;
    logic [1:0]             type_code;
    logic [3:0]             label_kind;
    logic [LABEL_BITS-1:0]  label_number;
    logic [2:0]             error_code;
    logic                   last_of_run;

    modport source (output valid, opcode, operand_kind, operand_handle, type_code,
                    label_kind, label_number, error_code, last_of_run, input ready);
    modport sink   (input valid, opcode, operand_kind, operand_handle, type_code,
                    label_kind, label_number, error_code, last_of_run, output ready);
endinterface

### hdl/bltt_front.sv
module bltt_front #(
    parameter int NEST_DEPTH  = 16,
    parameter int LABEL_BITS  = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    bltt_token_if.sink             i_tok,
    input  logic                   i_full,
    output logic                   o_push,
    output logic                   o_two,
    output bltt_pkg::t_code        o_code,
    output logic [HANDLE_BITS-1:0] o_handle,
    output logic [LABEL_BITS-1:0]  o_label,
    output logic [2:0]             o_err1
);
    import bltt_pkg::*;

    localparam int DW = $clog2(NEST_DEPTH + 1);
    localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int EW = LABEL_BITS + 2;

    logic [EW-1:0]         r_mem [NEST_DEPTH];
    logic [EW-1:0]         r_below;
    logic [1:0]            r_top_kind, n_top_kind;
    logic [LABEL_BITS-1:0] r_top_num, n_top_num;
    logic [DW-1:0]         r_depth, n_depth;
    logic [DW-1:0]         r_begin, n_begin;
    logic [LABEL_BITS:0]   r_next_if, n_next_if;
    logic [LABEL_BITS:0]   r_next_wh, n_next_wh;
    logic [LABEL_BITS-1:0] r_lci, n_lci;
    logic                  r_civ, n_civ;
    logic [DW-1:0]         r_oif, n_oif;
    logic [DW-1:0]         r_oel, n_oel;
    logic [DW-1:0]         r_owh, n_owh;
    logic                  r_drop, n_drop;

    logic                  accept;
    logic                  full;
    logic                  inst;
    logic [2:0]            err;
    logic [2:0]            fin;
    logic                  wen;
    logic [DW-1:0]         wr_full, rd_depth, rd_full;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [5:0]            kind;

    assign kind        = i_tok.token_kind;
    assign i_tok.ready = !i_full;
    assign accept      = i_tok.valid && !i_full;
    assign full        = (r_depth >= DW'(NEST_DEPTH));

    assign wr_full  = r_depth - DW'(1);
    assign wr_addr  = wr_full[AW-1:0];
    assign rd_depth = accept ? n_depth : r_depth;
    assign rd_full  = rd_depth - DW'(2);
    assign rd_addr  = rd_full[AW-1:0];

    always_comb begin
        inst       = 1'b0;
        err        = ERR_OK;
        fin        = ERR_OK;
        wen        = 1'b0;
        o_code     = '0;
        o_handle   = '0;
        o_label    = '0;
        o_two      = 1'b0;
        o_err1     = ERR_OK;
        o_push     = 1'b0;
        n_top_kind = r_top_kind;
        n_top_num  = r_top_num;
        n_depth    = r_depth;
        n_begin    = r_begin;
        n_next_if  = r_next_if;
        n_next_wh  = r_next_wh;
        n_lci      = r_lci;
        n_civ      = r_civ;
        n_oif      = r_oif;
        n_oel      = r_oel;
        n_owh      = r_owh;
        n_drop     = r_drop;

        if (!r_drop) begin
            if (kind <= TK_STRING) begin
                inst                = 1'b1;
                o_code.opcode       = OP_PUSH;
                o_code.operand_kind = OK_NAME + kind[3:0];
                o_handle            = i_tok.text_handle;
            end else if (kind <= TK_SET_STRING) begin
                inst                = 1'b1;
                o_code.opcode       = OP_SET_TYPE;
                o_code.operand_kind = OK_TYPE;
                o_code.type_code    = 2'(kind - TK_SET_INT);
            end else if (kind <= TK_ASSIGN) begin
                inst          = 1'b1;
                o_code.opcode = 5'(kind - TK_OP_OFFSET);
            end else if (kind <= TK_END) begin
                case (kind)
                    TK_SET_LABEL: begin
                        inst                = 1'b1;
                        o_code.opcode       = OP_SET_LABEL;
                        o_code.operand_kind = OK_USER;
                        o_handle            = i_tok.text_handle;
                    end
                    TK_GOTO: begin
                        inst          = 1'b1;
                        o_code.opcode = OP_GOTO;
                    end
                    TK_IF: begin
                        if (full || r_next_if[LABEL_BITS]) begin
                            err = ERR_OVERFLOW;
                        end else begin
                            inst                = 1'b1;
                            o_code.opcode       = OP_IF;
                            o_code.operand_kind = OK_BLOCK;
                            o_code.label_kind   = LK_IF;
                            o_label             = r_next_if[LABEL_BITS-1:0];
                            n_next_if           = r_next_if + 1'b1;
                            n_oif               = r_oif + 1'b1;
                            n_depth             = r_depth + 1'b1;
                            wen                 = (r_depth != '0);
                            n_top_kind          = BK_IF;
                            n_top_num           = r_next_if[LABEL_BITS-1:0];
                        end
                    end
                    TK_ELSE: begin
                        if (!r_civ) begin
                            err = ERR_ELSE;
                        end else if (full) begin
                            err = ERR_OVERFLOW;
                        end else begin
                            inst                = 1'b1;
                            o_code.opcode       = OP_ELSE;
                            o_code.operand_kind = OK_BLOCK;
                            o_code.label_kind   = LK_ELSE;
                            o_label             = r_lci;
                            n_oel               = r_oel + 1'b1;
                            n_depth             = r_depth + 1'b1;
                            wen                 = (r_depth != '0);
                            n_top_kind          = BK_ELSE;
                            n_top_num           = r_lci;
                        end
                    end
                    TK_WHILE: begin
                        if (full || r_next_wh[LABEL_BITS]) begin
                            err = ERR_OVERFLOW;
                        end else begin
                            inst                = 1'b1;
                            o_code.opcode       = OP_WHILE;
                            o_code.operand_kind = OK_BLOCK;
                            o_code.label_kind   = LK_WHILE;
                            o_label             = r_next_wh[LABEL_BITS-1:0];
                            n_next_wh           = r_next_wh + 1'b1;
                            n_owh               = r_owh + 1'b1;
                            n_depth             = r_depth + 1'b1;
                            wen                 = (r_depth != '0);
                            n_top_kind          = BK_WHILE;
                            n_top_num           = r_next_wh[LABEL_BITS-1:0];
                        end
                    end
                    TK_BEGIN: begin
                        if (r_depth == '0) begin
                            err = ERR_BEGIN;
                        end else if (r_begin >= DW'(NEST_DEPTH)) begin
                            err = ERR_OVERFLOW;
                        end else begin
                            inst                = 1'b1;
                            o_code.opcode       = OP_BEGIN;
                            o_code.operand_kind = OK_BLOCK;
                            o_code.label_kind   = {2'b00, r_top_kind} + LK_BEGIN_OFS;
                            o_label             = r_top_num;
                            n_begin             = r_begin + 1'b1;
                        end
                    end
                    TK_END: begin
                        if (r_depth == '0 || r_begin == '0) begin
                            err = ERR_END;
                        end else begin
                            inst                = 1'b1;
                            o_code.opcode       = OP_END;
                            o_code.operand_kind = OK_BLOCK;
                            o_code.label_kind   = {2'b00, r_top_kind} + LK_END_OFS;
                            o_label             = r_top_num;
                            n_depth             = r_depth - 1'b1;
                            n_begin             = r_begin - 1'b1;
                            // pop: the entry below becomes the top
                            n_top_kind          = r_below[EW-1 -: 2];
                            n_top_num           = r_below[LABEL_BITS-1:0];
                            if (r_top_kind == BK_IF) begin
                                n_oif = r_oif - 1'b1;
                                n_lci = r_top_num;
                                n_civ = 1'b1;
                            end else if (r_top_kind == BK_ELSE) begin
                                n_oel = r_oel - 1'b1;
                            end else begin
                                n_owh = r_owh - 1'b1;
                            end
                        end
                    end
                    default: begin
                        inst = 1'b0;
                    end
                endcase
            end else if (kind <= TK_GET_VAR) begin
                inst          = 1'b1;
                o_code.opcode = 5'(kind - TK_OP_OFFSET);
            end else if (kind == TK_EXIT) begin
                inst          = 1'b1;
                o_code.opcode = OP_EXIT;
            end

            // Closing checks see the counts after this token
            if (n_oif != '0) begin
                fin = ERR_OPEN_IF;
            end else if (n_oel != '0) begin
                fin = ERR_OPEN_ELSE;
            end else if (n_owh != '0) begin
                fin = ERR_OPEN_WHILE;
            end

            if (err != ERR_OK) begin
                o_code            = '0;
                o_code.error_code = err;
                o_handle          = '0;
                o_label           = '0;
                o_push            = 1'b1;
                n_drop            = !i_tok.end_of_program;
            end else if (i_tok.end_of_program) begin
                o_push = 1'b1;
                if (inst) begin
                    o_two  = 1'b1;
                    o_err1 = fin;
                end else begin
                    o_code = '0;
                    if (fin != ERR_OK) begin
                        o_code.error_code = fin;
                    end else begin
                        o_code.opcode = OP_EXIT;
                    end
                end
            end else begin
                o_push = inst;
            end
        end

        // End of program returns everything to the reset state
        if (i_tok.end_of_program) begin
            n_depth   = '0;
            n_begin   = '0;
            n_next_if = '0;
            n_next_wh = '0;
            n_lci     = '0;
            n_civ     = 1'b0;
            n_oif     = '0;
            n_oel     = '0;
            n_owh     = '0;
            n_drop    = 1'b0;
        end

        o_push = o_push && accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_begin   <= '0;
            r_next_if <= '0;
            r_next_wh <= '0;
            r_lci     <= '0;
            r_civ     <= 1'b0;
            r_oif     <= '0;
            r_oel     <= '0;
            r_owh     <= '0;
            r_drop    <= 1'b0;
        end else if (accept) begin
            r_depth   <= n_depth;
            r_begin   <= n_begin;
            r_next_if <= n_next_if;
            r_next_wh <= n_next_wh;
            r_lci     <= n_lci;
            r_civ     <= n_civ;
            r_oif     <= n_oif;
            r_oel     <= n_oel;
            r_owh     <= n_owh;
            r_drop    <= n_drop;
        end
    end

    // Top of stack lives in flops; the memory holds the entries below it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top_kind <= n_top_kind;
            r_top_num  <= n_top_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wen) begin
            r_mem[wr_addr] <= {r_top_kind, r_top_num};
        end
        if (accept && wen && (wr_addr == rd_addr)) begin
            r_below <= {r_top_kind, r_top_num};
        end else begin
            r_below <= r_mem[rd_addr];
        end
    end

endmodule

### hdl/bltt_queue.sv
module bltt_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);
    import bltt_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          pop;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rp];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

### hdl/bltt_back.sv
module bltt_back #(
    parameter int LABEL_BITS  = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_two,
    input  bltt_pkg::t_code        i_code,
    input  logic [HANDLE_BITS-1:0] i_handle,
    input  logic [LABEL_BITS-1:0]  i_label,
    input  logic [2:0]             i_err1,
    output logic                   o_pop,
    bltt_instr_if.source           o_ins
);
    import bltt_pkg::*;

    logic r_phase, n_phase;
    logic take;

    assign o_ins.valid = i_valid;
    assign take        = i_valid && o_ins.ready;
    assign o_pop       = take && (r_phase || !i_two);
    assign n_phase     = take ? (!r_phase && i_two) : r_phase;

    always_comb begin
        if (r_phase) begin
            // second result: exit, or the closing error in its place
            o_ins.opcode         = (i_err1 == ERR_OK) ? OP_EXIT : OP_PUSH;
            o_ins.operand_kind   = '0;
            o_ins.operand_handle = '0;
            o_ins.type_code      = '0;
            o_ins.label_kind     = '0;
            o_ins.label_number   = '0;
            o_ins.error_code     = i_err1;
            o_ins.last_of_run    = 1'b1;
        end else begin
            o_ins.opcode         = i_code.opcode;
            o_ins.operand_kind   = i_code.operand_kind;
            o_ins.operand_handle = i_handle;
            o_ins.type_code      = i_code.type_code;
            o_ins.label_kind     = i_code.label_kind;
            o_ins.label_number   = i_label;
            o_ins.error_code     = i_code.error_code;
            o_ins.last_of_run    = !i_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

### hdl/block_label_token_translator_top.sv
// Path: a token's results are registered in the result queue, then offered at the output.
// Throughput: one token per cycle while each token gives one result and the output takes
//   it; a token that gives an instruction plus the exit or closing error gives two results.
//   The rate is set by the single-result output port behind a four-entry queue.
// Reset: synchronous, active low; clears counters, flags and the queue. The
//   nesting stack memory is not cleared and needs no clearing pass.
module block_label_token_translator_top #(
    parameter int NEST_DEPTH  = 16,
    parameter int LABEL_BITS  = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bltt_token_if.sink   i_tok,
    bltt_instr_if.source o_ins
);
    import bltt_pkg::*;

    // Queue entry: second-result flag, first result, closing code of the second
    localparam int QW = 1 + $bits(t_code) + HANDLE_BITS + LABEL_BITS + 3;

    logic                   push, full, q_valid, pop;
    logic                   f_two, q_two;
    t_code                  f_code, q_code;
    logic [HANDLE_BITS-1:0] f_handle, q_handle;
    logic [LABEL_BITS-1:0]  f_label, q_label;
    logic [2:0]             f_err1, q_err1;
    logic [QW-1:0]          q_in, q_out;

    // Front: classify each token, track the nesting stack, emit queue entries
    bltt_front #(
        .NEST_DEPTH  (NEST_DEPTH),
        .LABEL_BITS  (LABEL_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tok    (i_tok),
        .i_full   (full),
        .o_push   (push),
        .o_two    (f_two),
        .o_code   (f_code),
        .o_handle (f_handle),
        .o_label  (f_label),
        .o_err1   (f_err1)
    );

    assign q_in = {f_two, f_code, f_handle, f_label, f_err1};

    // Queue decouples token intake from result delivery
    bltt_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (pop)
    );

    assign {q_two, q_code, q_handle, q_label, q_err1} = q_out;

    // Back: deliver one or two results per entry, mark the last one
    bltt_back #(
        .LABEL_BITS  (LABEL_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_two    (q_two),
        .i_code   (q_code),
        .i_handle (q_handle),
        .i_label  (q_label),
        .i_err1   (q_err1),
        .o_pop    (pop),
        .o_ins    (o_ins)
    );

endmodule

### dv/tb_block_label_token_translator_top.sv
module tb_block_label_token_translator_top;
    import bltt_pkg::*;

    localparam int NEST_DEPTH   = 16;
    localparam int LABEL_BITS   = 16;
    localparam int HANDLE_BITS  = 16;
    localparam int LABEL_LIMIT  = 1 << LABEL_BITS;
    localparam int TOKEN_TARGET = 1650;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 10;

    // Codes that the package leaves unnamed
    localparam logic [5:0] TK_IDENT   = 6'd0;
    localparam logic [5:0] TK_INT     = 6'd1;
    localparam logic [5:0] TK_DOUBLE  = 6'd2;
    localparam logic [5:0] TK_LAST    = 6'd63;
    localparam logic [3:0] OK_NONE    = 4'd0;
    localparam logic [4:0] OP_NONE    = 5'd0;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] handle;
        logic        eop;
    } token_t;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [3:0]  operand_kind;
        logic [15:0] operand_handle;
        logic [1:0]  type_code;
        logic [3:0]  label_kind;
        logic [15:0] label_number;
        logic [2:0]  error_code;
        logic        last_of_run;
    } instr_t;

    // Translates every accepted token on its own copy of the nesting state and
    // holds the instructions that the block owes, oldest first.
    class instr_scoreboard;
        instr_t      expected_instrs[$];
        int          n_mismatch;
        int          n_checked;
        logic [1:0]  blk_kind [NEST_DEPTH];
        logic [15:0] blk_num  [NEST_DEPTH];
        int          nest_level;
        int          begin_level;
        int          next_if;
        int          next_while;
        int          open_if;
        int          open_else;
        int          open_while;
        logic [15:0] last_if_closed;
        bit          if_closed_seen;
        bit          dropping;

        function new();
            n_mismatch = 0;
            n_checked  = 0;
            clear_state();
        endfunction

        function void clear_state();
            nest_level     = 0;
            begin_level    = 0;
            next_if        = 0;
            next_while     = 0;
            open_if        = 0;
            open_else      = 0;
            open_while     = 0;
            last_if_closed = '0;
            if_closed_seen = 1'b0;
            dropping       = 1'b0;
        endfunction

        function instr_t make_instr(logic [4:0] op, logic [3:0] okind, logic [15:0] handle,
                                    logic [1:0] tcode, logic [3:0] lkind,
                                    logic [15:0] lnum, logic [2:0] err);
            instr_t r;
            r.opcode         = op;
            r.operand_kind   = okind;
            r.operand_handle = handle;
            r.type_code      = tcode;
            r.label_kind     = lkind;
            r.label_number   = lnum;
            r.error_code     = err;
            r.last_of_run    = 1'b0;
            return r;
        endfunction

        function void push_block(logic [1:0] kind, logic [15:0] num);
            blk_kind[nest_level] = kind;
            blk_num[nest_level]  = num;
            nest_level++;
            case (kind)
                BK_IF:   open_if++;
                BK_ELSE: open_else++;
                default: open_while++;
            endcase
        endfunction

        function void note_token(token_t t);
            instr_t      out[$];
            logic [2:0]  err;
            logic [1:0]  top_kind;
            logic [15:0] top_num;
            err = ERR_OK;
            // after an error, swallow everything up to the end of the program
            if (dropping) begin
                if (t.eop) clear_state();
                return;
            end
            if (t.kind == TK_IDENT) begin
                out = {out, make_instr(OP_PUSH, OK_NAME, t.handle, '0, '0, '0, ERR_OK)};
            end else if (t.kind <= TK_STRING) begin
                out = {out, make_instr(OP_PUSH, 4'(t.kind + 6'd1), t.handle, '0, '0, '0,
                                       ERR_OK)};
            end else if (t.kind <= TK_SET_STRING) begin
                out = {out, make_instr(OP_SET_TYPE, OK_TYPE, '0, 2'(t.kind - TK_SET_INT),
                                       '0, '0, ERR_OK)};
            end else if (t.kind <= TK_ASSIGN) begin
                out = {out, make_instr(5'(t.kind - TK_OP_OFFSET), OK_NONE, '0, '0, '0, '0,
                                       ERR_OK)};
            end else if (t.kind == TK_SET_LABEL) begin
                out = {out, make_instr(OP_SET_LABEL, OK_USER, t.handle, '0, '0, '0, ERR_OK)};
            end else if (t.kind == TK_GOTO) begin
                out = {out, make_instr(OP_GOTO, OK_NONE, '0, '0, '0, '0, ERR_OK)};
            end else if (t.kind == TK_IF) begin
                if (nest_level >= NEST_DEPTH || next_if >= LABEL_LIMIT) begin
                    err = ERR_OVERFLOW;
                end else begin
                    push_block(BK_IF, 16'(next_if));
                    out = {out, make_instr(OP_IF, OK_BLOCK, '0, '0, LK_IF, 16'(next_if),
                                           ERR_OK)};
                    next_if++;
                end
            end else if (t.kind == TK_ELSE) begin
                if (!if_closed_seen) begin
                    err = ERR_ELSE;
                end else if (nest_level >= NEST_DEPTH) begin
                    err = ERR_OVERFLOW;
                end else begin
                    push_block(BK_ELSE, last_if_closed);
                    out = {out, make_instr(OP_ELSE, OK_BLOCK, '0, '0, LK_ELSE, last_if_closed,
                                           ERR_OK)};
                end
            end else if (t.kind == TK_WHILE) begin
                if (nest_level >= NEST_DEPTH || next_while >= LABEL_LIMIT) begin
                    err = ERR_OVERFLOW;
                end else begin
                    push_block(BK_WHILE, 16'(next_while));
                    out = {out, make_instr(OP_WHILE, OK_BLOCK, '0, '0, LK_WHILE,
                                           16'(next_while), ERR_OK)};
                    next_while++;
                end
            end else if (t.kind == TK_BEGIN) begin
                if (nest_level == 0) begin
                    err = ERR_BEGIN;
                end else if (begin_level >= NEST_DEPTH) begin
                    err = ERR_OVERFLOW;
                end else begin
                    top_kind = blk_kind[nest_level - 1];
                    top_num  = blk_num[nest_level - 1];
                    begin_level++;
                    out = {out, make_instr(OP_BEGIN, OK_BLOCK, '0, '0,
                                           LK_BEGIN_OFS + 4'(top_kind), top_num, ERR_OK)};
                end
            end else if (t.kind == TK_END) begin
                if (nest_level == 0 || begin_level == 0) begin
                    err = ERR_END;
                end else begin
                    top_kind = blk_kind[nest_level - 1];
                    top_num  = blk_num[nest_level - 1];
                    nest_level--;
                    begin_level--;
                    case (top_kind)
                        BK_IF: begin
                            open_if--;
                            last_if_closed = top_num;
                            if_closed_seen = 1'b1;
                        end
                        BK_ELSE: open_else--;
                        default: open_while--;
                    endcase
                    out = {out, make_instr(OP_END, OK_BLOCK, '0, '0,
                                           LK_END_OFS + 4'(top_kind), top_num, ERR_OK)};
                end
            end else if (t.kind <= TK_GET_VAR) begin
                out = {out, make_instr(5'(t.kind - TK_OP_OFFSET), OK_NONE, '0, '0, '0, '0,
                                       ERR_OK)};
            end else if (t.kind == TK_EXIT) begin
                out = {out, make_instr(OP_EXIT, OK_NONE, '0, '0, '0, '0, ERR_OK)};
            end

            if (err != ERR_OK) begin
                out = {out, make_instr(OP_NONE, OK_NONE, '0, '0, '0, '0, err)};
                if (t.eop) clear_state();
                else dropping = 1'b1;
            end else if (t.eop) begin
                // closing checks replace the exit instruction
                if (open_if > 0) err = ERR_OPEN_IF;
                else if (open_else > 0) err = ERR_OPEN_ELSE;
                else if (open_while > 0) err = ERR_OPEN_WHILE;
                if (err != ERR_OK)
                    out = {out, make_instr(OP_NONE, OK_NONE, '0, '0, '0, '0, err)};
                else
                    out = {out, make_instr(OP_EXIT, OK_NONE, '0, '0, '0, '0, ERR_OK)};
                clear_state();
            end
            if (out.size() > 0) out[out.size() - 1].last_of_run = 1'b1;
            expected_instrs = {expected_instrs, out};
        endfunction

        function void report_mismatch(string msg);
            if (n_mismatch < 100) $display("mismatch: %s", msg);
            n_mismatch++;
        endfunction

        function void check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                          n_checked, name, got, want));
        endfunction

        function void check_instr(instr_t got);
            instr_t want;
            n_checked++;
            if (expected_instrs.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                          n_checked));
                return;
            end
            want = expected_instrs.pop_front();
            check_field("opcode", 16'(got.opcode), 16'(want.opcode));
            check_field("operand_kind", 16'(got.operand_kind), 16'(want.operand_kind));
            check_field("operand_handle", got.operand_handle, want.operand_handle);
            check_field("type_code", 16'(got.type_code), 16'(want.type_code));
            check_field("label_kind", 16'(got.label_kind), 16'(want.label_kind));
            check_field("label_number", got.label_number, want.label_number);
            check_field("error_code", 16'(got.error_code), 16'(want.error_code));
            check_field("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bltt_token_if #(.HANDLE_BITS(HANDLE_BITS)) tok_bus ();
    bltt_instr_if #(.HANDLE_BITS(HANDLE_BITS), .LABEL_BITS(LABEL_BITS)) ins_bus ();

    block_label_token_translator_top #(
        .NEST_DEPTH (NEST_DEPTH),
        .LABEL_BITS (LABEL_BITS),
        .HANDLE_BITS(HANDLE_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tok  (tok_bus),
        .o_ins  (ins_bus)
    );

    instr_scoreboard book = new();

    token_t token_feed[$];
    token_t prog[$];
    bit     prog_if_closed;
    int     max_nest;
    bit     calm;
    bit     hold_req;
    int     idle_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Program generator
    // ------------------------------------------------------------------

    function automatic token_t make_token(logic [5:0] kind, logic eop);
        token_t t;
        t.kind   = kind;
        t.handle = 16'($urandom);
        t.eop    = eop;
        return t;
    endfunction

    function automatic void add_token(logic [5:0] kind);
        prog = {prog, make_token(kind, 1'b0)};
    endfunction

    // Append one directed token to the feed
    function automatic void feed(logic [5:0] kind, logic [15:0] handle, logic eop);
        token_t t;
        t.kind     = kind;
        t.handle   = handle;
        t.eop      = eop;
        token_feed = {token_feed, t};
    endfunction

    // Any token that opens or closes nothing; a few unknown kinds mixed in.
    function automatic logic [5:0] plain_kind();
        int k;
        if ($urandom_range(19) == 0) return 6'($urandom_range(TK_LAST, TK_EXIT + 6'd1));
        do k = $urandom_range(TK_EXIT); while (k >= TK_IF && k <= TK_END);
        return 6'(k);
    endfunction

    function automatic void gen_block(int lvl);
        logic [5:0] opener;
        int         r;
        r = $urandom_range(99);
        // an else is only legal once some if has closed in this program
        if (prog_if_closed && r < 30) opener = TK_ELSE;
        else if (r < 65) opener = TK_IF;
        else opener = TK_WHILE;
        add_token(opener);
        add_token(TK_BEGIN);
        gen_stmts(lvl + 1, $urandom_range(3));
        add_token(TK_END);
        if (opener == TK_IF) prog_if_closed = 1'b1;
    endfunction

    function automatic void gen_stmts(int lvl, int count);
        for (int i = 0; i < count; i++) begin
            if (lvl < max_nest && $urandom_range(99) < 30) gen_block(lvl);
            else add_token(plain_kind());
        end
    endfunction

    // Build one program into prog: mostly well-formed nesting with random
    // content, the rest pushes the stack limits or breaks the structure.
    function automatic void build_program();
        int pick;
        int n;
        int pos;
        prog.delete();
        prog_if_closed = 1'b0;
        max_nest = ($urandom_range(9) == 0) ? NEST_DEPTH : 3;
        pick = $urandom_range(99);
        if (pick < 62) begin
            gen_stmts(0, $urandom_range(8, 1));
        end else if (pick < 70) begin
            // chain of nested blocks up to and just past a full stack
            n = $urandom_range(NEST_DEPTH + 1, 12);
            for (int i = 0; i < n; i++) begin
                add_token($urandom_range(1) ? TK_IF : TK_WHILE);
                add_token(TK_BEGIN);
            end
            for (int i = 0; i < n; i++) add_token(TK_END);
        end else if (pick < 76) begin
            // pile begins on one block until the begin count runs out
            n = $urandom_range(NEST_DEPTH + 1, 14);
            add_token(TK_WHILE);
            repeat (n) add_token(TK_BEGIN);
            add_token(TK_END);
        end else if (pick < 81) begin
            // else with the stack full or nearly so
            add_token(TK_IF);
            add_token(TK_BEGIN);
            add_token(TK_END);
            n = $urandom_range(NEST_DEPTH, NEST_DEPTH - 2);
            repeat (n) add_token(TK_IF);
            add_token(TK_ELSE);
        end else if (pick < 93) begin
            // well-formed body with one structural slip
            gen_stmts(0, $urandom_range(6, 2));
            pos = $urandom_range(prog.size() - 1);
            case ($urandom_range(2))
                0: prog.delete(pos);
                1: prog.insert(pos, make_token(6'($urandom_range(TK_END, TK_IF)), 1'b0));
                default: while (prog.size() > pos + 1) prog.delete(prog.size() - 1);
            endcase
        end else begin
            repeat ($urandom_range(10, 1)) add_token(6'($urandom_range(TK_LAST)));
        end
        if ($urandom_range(3) == 0 || prog.size() == 0) add_token(TK_EXIT);
        prog[prog.size() - 1].eop = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Token driver
    // ------------------------------------------------------------------

    // Offer one token and hold it until the block takes it. Idle cycles go in
    // front of the token unless the calm stretch is on.
    task automatic send_token(token_t t);
        while (!calm && $urandom_range(99) < 27) begin
            tok_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        tok_bus.valid          <= 1'b1;
        tok_bus.token_kind     <= t.kind;
        tok_bus.text_handle    <= t.handle;
        tok_bus.end_of_program <= t.eop;
        @(posedge i_clk);
        while (!tok_bus.ready) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Instruction sink: random back-pressure, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : sink_proc
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        ins_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                // hold off long enough for the result queue to fill and the
                // token side to stall
                hold_left--;
                ins_bus.ready <= 1'b0;
            end else begin
                ins_bus.ready <= calm || ($urandom_range(99) >= 27);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes on the pre-edge values
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && tok_bus.valid && tok_bus.ready)
            book.note_token({tok_bus.token_kind, tok_bus.text_handle,
                             tok_bus.end_of_program});
        if (i_rst_n && ins_bus.valid && ins_bus.ready)
            book.check_instr({ins_bus.opcode, ins_bus.operand_kind, ins_bus.operand_handle,
                              ins_bus.type_code, ins_bus.label_kind, ins_bus.label_number,
                              ins_bus.error_code, ins_bus.last_of_run});
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles with no transaction on either side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((tok_bus.valid && tok_bus.ready) || (ins_bus.valid && ins_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        idle_cycles = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        tok_bus.valid          <= 1'b0;
        tok_bus.token_kind     <= '0;
        tok_bus.text_handle    <= '0;
        tok_bus.end_of_program <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every block kind with begin and end, handle extremes,
        // an unknown kind, exit on the last token; then each error but overflow on its own.
        feed(TK_IF, 16'h0000, 1'b0);
        feed(TK_BEGIN, 16'h0000, 1'b0);
        feed(TK_IDENT, 16'hFFFF, 1'b0);
        feed(TK_END, 16'h0000, 1'b0);
        feed(TK_ELSE, 16'hFFFF, 1'b0);
        feed(TK_BEGIN, 16'h0000, 1'b0);
        feed(TK_INT, 16'h0000, 1'b0);
        feed(TK_END, 16'h0000, 1'b0);
        feed(TK_WHILE, 16'h0000, 1'b0);
        feed(TK_BEGIN, 16'h0000, 1'b0);
        feed(TK_SET_LABEL, 16'hA5A5, 1'b0);
        feed(TK_END, 16'h0000, 1'b0);
        feed(TK_LAST, 16'h5A5A, 1'b0);
        feed(TK_EXIT, 16'hFFFF, 1'b1);
        // else with no closed if, ending the program at once
        feed(TK_ELSE, 16'h0000, 1'b1);
        // begin with nothing open, then tokens that must be dropped
        feed(TK_BEGIN, 16'h0000, 1'b0);
        feed(TK_DOUBLE, 16'h1234, 1'b0);
        feed(TK_IDENT, 16'hFFFF, 1'b1);
        // end with nothing open
        feed(TK_END, 16'h0000, 1'b1);
        // open if, open else, open while at end of program
        feed(TK_IF, 16'h0000, 1'b1);
        feed(TK_IF, 16'h0000, 1'b0);
        feed(TK_BEGIN, 16'h0000, 1'b0);
        feed(TK_END, 16'h0000, 1'b0);
        feed(TK_ELSE, 16'h0000, 1'b1);
        feed(TK_WHILE, 16'h0000, 1'b1);

        // Random programs after the directed part
        while (token_feed.size() < TOKEN_TARGET) begin
            build_program();
            token_feed = {token_feed, prog};
        end

        foreach (token_feed[i]) begin
            // one long back-pressure hold early on, a calm stretch later
            if (i == 300) hold_req = 1'b1;
            calm = (i >= 800 && i < 1100);
            send_token(token_feed[i]);
        end
        tok_bus.valid <= 1'b0;

        // Drain: let the monitor note the last token, wait for every
        // outstanding instruction, then a short pause to catch anything extra.
        @(posedge i_clk);
        while (book.expected_instrs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.n_mismatch == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
